>>> rtl/arla_pkg.sv
package arla_pkg;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;
  localparam int TOL_BITS      = 12;
  localparam int SPAN_BITS     = 12;
  localparam int DZ_BITS       = 7;
  localparam int AXIS_BITS     = 16;
  localparam int QUOT_BITS     = 17;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPAN      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEADZONE  = 2'd2;

  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_CALIBRATE = 1'b1;

  localparam logic [TOL_BITS-1:0]  TOL_RESET  = 12'd82;
  localparam logic [SPAN_BITS-1:0] SPAN_RESET = 12'd50;
  localparam logic [DZ_BITS-1:0]   DZ_RESET   = 7'd10;

  localparam logic [DZ_BITS-1:0]     PCT_SCALE = 7'd100;
  localparam logic [QUOT_BITS:0]     AXIS_LOW  = 18'd32767;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } arla_state_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } arla_div_stat_t;

endpackage

>>> rtl/arla_div.sv
module arla_div #(
  parameter int DEN_BITS = 13,
  parameter int DVD_BITS = 29
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [DVD_BITS-1:0]                dividend,
  input  logic [DEN_BITS-1:0]                divisor,
  output logic [arla_pkg::QUOT_BITS-1:0]     quotient,
  output arla_pkg::arla_div_stat_t           stat
);

  localparam int CNT_BITS = $clog2(DVD_BITS + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_BITS-1:0]   cnt;
  logic [DVD_BITS-1:0]   dvd_sr;
  logic [DEN_BITS-1:0]   rem;
  logic [DEN_BITS:0]     shifted;
  logic                  fits;

  // one quotient bit per cycle, dividend shifted out msb first
  assign shifted = {rem, dvd_sr[DVD_BITS-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DVD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_sr   <= dividend;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd_sr   <= {dvd_sr[DVD_BITS-2:0], 1'b0};
      rem      <= fits ? DEN_BITS'(shifted - {1'b0, divisor}) : shifted[DEN_BITS-1:0];
      quotient <= {quotient[arla_pkg::QUOT_BITS-2:0], fits};
    end
  end

  assign stat.done   = done;
  assign stat.rem_nz = |rem;

endmodule

>>> rtl/auto_ranging_lever_axis.sv
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  op, sample, run_mode, link_up
// out      out  out_valid / out_stall axis_value
// cfg      in   cfg_we               cfg_index, cfg_data
//
// Calibrate, setup-mode, small-change and no-result items never enter the divider.
// An item with a result runs through the bit-serial divider, which retires one
// quotient bit per cycle; the input stalls until the item is finished.
// Synchronous reset restores register defaults and clears position and range.
// The result waits in an output register; a stalled result holds the block in
// its final state until the register frees.
module auto_ranging_lever_axis #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   op,
  input  logic [SAMPLE_BITS-1:0]                 sample,
  input  logic                                   run_mode,
  input  logic                                   link_up,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [arla_pkg::AXIS_BITS-1:0]  axis_value,
  input  logic                                   cfg_we,
  input  logic [arla_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [arla_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int RB = SAMPLE_BITS + 1;
  localparam int WW = (SAMPLE_BITS > arla_pkg::TOL_BITS) ? SAMPLE_BITS : arla_pkg::TOL_BITS;
  localparam int CW = WW + 1;
  localparam int PW = RB + arla_pkg::AXIS_BITS;
  localparam int MW = RB + arla_pkg::DZ_BITS;
  localparam logic [CW-1:0] RMAX_W = CW'({RB{1'b1}});

  arla_pkg::arla_state_t state, state_next;

  logic [arla_pkg::TOL_BITS-1:0]  change_tolerance;
  logic [arla_pkg::SPAN_BITS-1:0] initial_span;
  logic [arla_pkg::DZ_BITS-1:0]   deadzone_percent;

  logic [SAMPLE_BITS-1:0] lever_pos;
  logic [SAMPLE_BITS-1:0] range_min;
  logic [RB-1:0]          range_max;
  logic [RB-1:0]          num;
  logic [RB-1:0]          den;
  logic                   below_half;

  logic                   accept;
  logic                   div_start;
  logic                   out_load;
  logic [SAMPLE_BITS-1:0] diff;
  logic                   moved;
  logic [CW-1:0]          top;
  logic [RB-1:0]          cal_max;
  logic [RB-1:0]          new_max;
  logic                   emit;
  logic [MW-1:0]          pct_lhs;
  logic [MW-1:0]          pct_rhs;
  logic [RB-1:0]          num_eff;
  logic [PW-1:0]          prod;
  logic [arla_pkg::QUOT_BITS:0]      val;
  logic [arla_pkg::QUOT_BITS-1:0]    quotient;
  arla_pkg::arla_div_stat_t          div_stat;

  assign accept = in_valid && !in_stall;

  assign diff    = (lever_pos > sample) ? lever_pos - sample : sample - lever_pos;
  assign moved   = WW'(diff) >= WW'(change_tolerance);
  assign top     = CW'(sample) + CW'(initial_span);
  assign cal_max = (top > RMAX_W) ? {RB{1'b1}} : top[RB-1:0];
  assign new_max = ({1'b0, sample} > range_max) ? {1'b0, sample} : range_max;
  assign emit    = (new_max > {1'b0, range_min}) && link_up;

  // dead zone: num*100 < dz*den
  assign pct_lhs = MW'(num) * MW'(arla_pkg::PCT_SCALE);
  assign pct_rhs = MW'(deadzone_percent) * MW'(den);
  assign num_eff = (pct_lhs < pct_rhs) ? '0 : num;
  // 65534*num = (num << 16) - (num << 1)
  assign prod    = (PW'(num_eff) << arla_pkg::AXIS_BITS) - (PW'(num_eff) << 1);

  always_comb begin
    state_next = state;
    unique case (state)
      arla_pkg::ST_IDLE: begin
        if (accept && (op == arla_pkg::OP_SAMPLE) && run_mode && moved && emit)
          state_next = arla_pkg::ST_PREP;
      end
      arla_pkg::ST_PREP: state_next = arla_pkg::ST_DIV;
      arla_pkg::ST_DIV: begin
        if (div_stat.done) state_next = arla_pkg::ST_FIN;
      end
      arla_pkg::ST_FIN: begin
        if (!out_valid || !out_stall) state_next = arla_pkg::ST_IDLE;
      end
      default: state_next = arla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != arla_pkg::ST_IDLE);
    div_start = (state == arla_pkg::ST_PREP);
    out_load  = (state == arla_pkg::ST_FIN) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arla_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      change_tolerance <= arla_pkg::TOL_RESET;
      initial_span     <= arla_pkg::SPAN_RESET;
      deadzone_percent <= arla_pkg::DZ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arla_pkg::CFG_TOLERANCE: change_tolerance <= cfg_data;
        arla_pkg::CFG_SPAN:      initial_span     <= cfg_data;
        arla_pkg::CFG_DEADZONE:  deadzone_percent <= cfg_data[arla_pkg::DZ_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lever_pos <= '0;
      range_min <= '0;
      range_max <= '0;
    end else if (accept) begin
      if (op == arla_pkg::OP_CALIBRATE) begin
        range_min <= sample;
        range_max <= cal_max;
        lever_pos <= sample;
      end else if (run_mode && moved) begin
        lever_pos <= sample;
        range_max <= new_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      den <= new_max - {1'b0, range_min};
      num <= (sample > range_min) ? {1'b0, sample - range_min} : '0;
    end
    if (div_start) begin
      below_half <= {num_eff, 1'b0} < {1'b0, den};
    end
  end

  arla_div #(
    .DEN_BITS (RB),
    .DVD_BITS (PW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // negative non-integer results round toward zero
  assign val = {1'b0, quotient} + {{arla_pkg::QUOT_BITS{1'b0}}, (div_stat.rem_nz && below_half)}
               - arla_pkg::AXIS_LOW;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      axis_value <= val[arla_pkg::AXIS_BITS-1:0];
    end
  end

endmodule
